@@ rtl/core/prc_pkg.sv @@
// Shared constants and the arctangent table of the polar/rectangular converter.
`timescale 1ns / 1ps

package prc_pkg;

    // Number of CORDIC iterations by default, and the longest table available.
    localparam int ITERATIONS_DEF = 16;
    localparam int TABLE_LEN      = 24;

    // Guard bits added below the 16-bit inputs.
    localparam int GUARD_BITS = 8;

    // Datapath width: 16 bits of input, guard bits, and headroom for the gain.
    localparam int DATA_W = 16 + GUARD_BITS + 4;

    // Angle accumulator: 32 bits per turn plus a sign bit for rotation mode.
    localparam int ANGLE_W = 33;

    // Inverse CORDIC gain, 0.6072529350 scaled by 2^24.
    localparam int GAIN_W = 25;
    localparam logic signed [GAIN_W-1:0] INV_GAIN = 25'sd10188014;

    // Product width and the width that remains after the final shift by 32.
    localparam int PROD_W  = DATA_W + GAIN_W;
    localparam int SHIFT_W = PROD_W - 32;

    // Operation codes carried in tuser.
    localparam logic OP_TO_POLAR = 1'b0;
    localparam logic OP_TO_RECT  = 1'b1;

    // Arctangent of 2^-i, in units of 2^32 per turn.
    function automatic logic [31:0] atan_angle(input int idx);
        logic [31:0] val;
        unique case (idx)
            0:       val = 32'h20000000;
            1:       val = 32'h12E4051E;
            2:       val = 32'h09FB385B;
            3:       val = 32'h051111D4;
            4:       val = 32'h028B0D43;
            5:       val = 32'h0145D7E1;
            6:       val = 32'h00A2F61E;
            7:       val = 32'h00517C55;
            8:       val = 32'h0028BE53;
            9:       val = 32'h00145F2F;
            10:      val = 32'h000A2F98;
            11:      val = 32'h000517CC;
            12:      val = 32'h00028BE6;
            13:      val = 32'h000145F3;
            14:      val = 32'h0000A2FA;
            15:      val = 32'h0000517D;
            16:      val = 32'h000028BE;
            17:      val = 32'h0000145F;
            18:      val = 32'h00000A30;
            19:      val = 32'h00000518;
            20:      val = 32'h0000028C;
            21:      val = 32'h00000146;
            22:      val = 32'h000000A3;
            23:      val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/polar_rectangular_converter.sv @@
// Pipelined CORDIC converter between rectangular and polar coordinates.
`timescale 1ns / 1ps

// The converter takes one word per clock and returns one word per clock, in order,
// while the output accepts words. A word passes through the quadrant pre-rotation
// stage, one CORDIC stage for each iteration, the gain-compensating multiply stage
// and the rounding and saturation stage. Each stage holds while it is full and its
// successor cannot load, so a stalled output fills the empty stages
// first and nothing is dropped or repeated. With tuser low, tdata (x, y) becomes
// magnitude and binary angle (32768 is pi, the origin gives zero for both). With
// tuser high, tdata (radius, angle) becomes (x, y), saturated to the result widths.
module polar_rectangular_converter
    import prc_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] first_value, [31:16] second_value
    input  logic        s_axis_tuser,  // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // [16:0] first_result, [32:17] second_result, zero pad
);

    localparam int STAGES = ITERATIONS + 3;
    localparam int MUL_ST = ITERATIONS + 1;
    localparam int OUT_ST = ITERATIONS + 2;

    // Stage valid bits and per-stage advance enables.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] ready;

    // CORDIC stage payload: stage 0 is the pre-rotation, stage k+1 follows iteration k.
    logic signed [DATA_W-1:0]  x_reg    [0:ITERATIONS];
    logic signed [DATA_W-1:0]  y_reg    [0:ITERATIONS];
    logic signed [ANGLE_W-1:0] z_reg    [0:ITERATIONS];
    logic                      op_reg   [0:ITERATIONS];
    logic                      zero_reg [0:ITERATIONS];

    logic signed [DATA_W-1:0]  x_next   [1:ITERATIONS];
    logic signed [DATA_W-1:0]  y_next   [1:ITERATIONS];
    logic signed [ANGLE_W-1:0] z_next   [1:ITERATIONS];

    // Pre-rotation stage.
    logic signed [DATA_W-1:0]  pre_x_next, pre_y_next;
    logic signed [ANGLE_W-1:0] pre_z_next;

    // Multiply stage.
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [15:0]              angle_reg;
    logic                     mul_op_reg, mul_zero_reg;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next;
    logic [31:0]              angle_sum;

    // Output stage.
    logic [16:0]               first_result_reg, first_result_next;
    logic [15:0]               second_result_reg, second_result_next;
    logic                      out_op_reg;
    logic signed [SHIFT_W-1:0] scaled_x, scaled_y;
    logic signed [PROD_W-1:0]  round_x, round_y;
    logic [16:0]               sat_x;
    logic [15:0]               sat_y;

    // Input decode.
    logic signed [DATA_W-1:0] in_a, in_b;
    logic                     in_swap;

    // A stage may load when it is empty or its contents move on.
    always_comb
    begin
        ready[STAGES-1] = !valid_reg[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign s_axis_tready = ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Pre-rotation by pi so that every quadrant lies within CORDIC reach.
    always_comb
    begin
        in_a    = DATA_W'($signed(s_axis_tdata[15:0])) <<< GUARD_BITS;
        in_b    = DATA_W'($signed(s_axis_tdata[31:16])) <<< GUARD_BITS;
        in_swap = 1'b0;
        pre_x_next = in_a;
        pre_y_next = in_b;
        pre_z_next = '0;
        if (s_axis_tuser == OP_TO_POLAR)
        begin
            if (in_a < 0)
            begin
                pre_x_next = -in_a;
                pre_y_next = -in_b;
                pre_z_next = ANGLE_W'(33'h080000000);
            end
        end
        else
        begin
            // Angles in the left half plane are turned by pi and x negated.
            in_swap    = s_axis_tdata[31] ^ s_axis_tdata[30];
            pre_y_next = '0;
            pre_z_next = ANGLE_W'($signed({s_axis_tdata[31] ^ in_swap,
                                           s_axis_tdata[30:16], 16'h0000}));
            if (in_swap)
            begin
                pre_x_next = -in_a;
            end
        end
    end

    // One CORDIC micro-rotation per stage.
    always_comb
    begin
        for (int k = 0; k < ITERATIONS; k++)
        begin
            logic                      ccw;
            logic signed [DATA_W-1:0]  xs, ys;
            logic signed [ANGLE_W-1:0] step;
            ccw  = op_reg[k] ? !z_reg[k][ANGLE_W-1] : y_reg[k][DATA_W-1];
            xs   = x_reg[k] >>> k;
            ys   = y_reg[k] >>> k;
            step = $signed({1'b0, atan_angle(k)});
            if (ccw)
            begin
                x_next[k+1] = x_reg[k] - ys;
                y_next[k+1] = y_reg[k] + xs;
                z_next[k+1] = z_reg[k] - step;
            end
            else
            begin
                x_next[k+1] = x_reg[k] + ys;
                y_next[k+1] = y_reg[k] - xs;
                z_next[k+1] = z_reg[k] + step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            x_reg[0]    <= pre_x_next;
            y_reg[0]    <= pre_y_next;
            z_reg[0]    <= pre_z_next;
            op_reg[0]   <= s_axis_tuser;
            zero_reg[0] <= (s_axis_tdata[15:0] == 16'h0000) && (s_axis_tdata[31:16] == 16'h0000);
        end
        for (int k = 1; k <= ITERATIONS; k++)
        begin
            if (ready[k])
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                op_reg[k]   <= op_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    // Gain compensation and angle rounding.
    always_comb
    begin
        prod_x_next = PROD_W'(x_reg[ITERATIONS]) * PROD_W'(INV_GAIN);
        prod_y_next = PROD_W'(y_reg[ITERATIONS]) * PROD_W'(INV_GAIN);
        angle_sum   = z_reg[ITERATIONS][31:0] + 32'h00008000;
    end

    always_ff @(posedge clk)
    begin
        if (ready[MUL_ST])
        begin
            prod_x_reg   <= prod_x_next;
            prod_y_reg   <= prod_y_next;
            angle_reg    <= angle_sum[31:16];
            mul_op_reg   <= op_reg[ITERATIONS];
            mul_zero_reg <= zero_reg[ITERATIONS];
        end
    end

    // Drop guard and gain scale with rounding half up, then saturate.
    always_comb
    begin
        round_x  = prod_x_reg + PROD_W'(64'h80000000);
        round_y  = prod_y_reg + PROD_W'(64'h80000000);
        scaled_x = SHIFT_W'(round_x >>> 32);
        scaled_y = SHIFT_W'(round_y >>> 32);
        if (scaled_x > SHIFT_W'(65535))
        begin
            sat_x = 17'h0FFFF;
        end
        else if (scaled_x < -SHIFT_W'(65536))
        begin
            sat_x = 17'h10000;
        end
        else
        begin
            sat_x = scaled_x[16:0];
        end
        if (scaled_y > SHIFT_W'(32767))
        begin
            sat_y = 16'h7FFF;
        end
        else if (scaled_y < -SHIFT_W'(32768))
        begin
            sat_y = 16'h8000;
        end
        else
        begin
            sat_y = scaled_y[15:0];
        end
        if (mul_op_reg == OP_TO_RECT)
        begin
            first_result_next  = sat_x;
            second_result_next = sat_y;
        end
        else if (mul_zero_reg)
        begin
            first_result_next  = '0;
            second_result_next = '0;
        end
        else
        begin
            first_result_next  = sat_x;
            second_result_next = angle_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[OUT_ST])
        begin
            first_result_reg  <= first_result_next;
            second_result_reg <= second_result_next;
            out_op_reg        <= mul_op_reg;
        end
    end

    assign m_axis_tvalid = valid_reg[OUT_ST];
    assign m_axis_tdata  = {7'b0, second_result_reg, first_result_reg};

    // An empty output stage lets every stage behind it move.
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[OUT_ST] |-> s_axis_tready)
        else $error("input stalled although the output stage is empty");

    // A magnitude is never negative.
    a_magnitude_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_op_reg == OP_TO_POLAR) |-> !first_result_reg[16])
        else $error("negative magnitude on the output");

    // A word in the multiply stage that cannot move keeps the output occupied.
    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[MUL_ST] && !ready[MUL_ST]) |-> (m_axis_tvalid && !m_axis_tready))
        else $error("multiply stage blocked without a stalled output word");

endmodule

@@ bench/prc_conversion_checker.sv @@
// Checker for the polar/rectangular converter: predicts each conversion and compares results.
`timescale 1ns / 1ps

module prc_conversion_checker
    import prc_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_data,       // [15:0] first_value, [31:16] second_value
    input  logic        s_user,       // [0] op
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [39:0] m_data,       // [16:0] first_result, [32:17] second_result
    output int          mismatch_count,
    output int          words_in_flight
);

    // One converted pair: magnitude/x and angle/y.
    typedef struct packed {
        logic signed [16:0] first_result;
        logic signed [15:0] second_result;
    } coord_result_t;

    // An accepted input word together with the result it should produce.
    typedef struct {
        logic               op;
        logic signed [15:0] first_value;
        logic signed [15:0] second_value;
        coord_result_t      result;
    } conversion_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    logic [31:0] atan_lut [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    conversion_t awaited_results [$];
    conversion_t head;
    conversion_t incoming;
    coord_result_t observed;

    initial mismatch_count = 0;
    initial words_in_flight = 0;

    // Removes the CORDIC gain and the guard bits, rounding half up.
    function automatic longint remove_gain(input longint v);
        return (v * longint'(INV_GAIN) + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Fixed-point CORDIC conversion in either direction.
    function automatic coord_result_t convert_pair(input logic op,
                                                   input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        coord_result_t res;
        longint x, y, xs, ys, zs, step;
        bit [31:0] acc, z, rounded;
        res = '0;
        acc = 32'h0;
        x = longint'(a) * (64'sd1 <<< GUARD_BITS);
        if (op == OP_TO_POLAR)
        begin
            // The origin has no angle; both results are zero.
            if (a == 0 && b == 0)
                return res;
            y = longint'(b) * (64'sd1 <<< GUARD_BITS);
            // Points left of the y axis are turned by pi first.
            if (x < 0)
            begin
                x = -x;
                y = -y;
                acc = 32'h80000000;
            end
            for (int i = 0; i < ITERATIONS && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    acc = acc + atan_lut[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    acc = acc - atan_lut[i];
                end
            end
            rounded = acc + 32'h8000;
            res.first_result  = 17'(saturate(remove_gain(x), -65536, 65535));
            res.second_result = rounded[31:16];
        end
        else
        begin
            y = 0;
            z = {b, 16'h0000};
            // Angles in the left half plane are folded by pi.
            if (z >= 32'h40000000 && z < 32'hC0000000)
            begin
                z = z - 32'h80000000;
                x = -x;
            end
            zs = longint'(signed'(z));
            for (int i = 0; i < ITERATIONS && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                step = $signed({32'd0, atan_lut[i]});
                if (zs >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    zs = zs - step;
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    zs = zs + step;
                end
            end
            res.first_result  = 17'(saturate(remove_gain(x), -65536, 65535));
            res.second_result = 16'(saturate(remove_gain(y), -32768, 32767));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compare results against the oldest prediction, then record new inputs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_valid && m_ready)
            begin
                observed.first_result  = m_data[16:0];
                observed.second_result = m_data[32:17];
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word %h with no input pending", m_data));
                end
                else
                begin
                    head = awaited_results.pop_front();
                    if (observed.first_result !== head.result.first_result)
                        report_mismatch($sformatf(
                            "op %0d in (%0d, %0d): first_result want %0d got %0d",
                            head.op, head.first_value, head.second_value,
                            head.result.first_result, observed.first_result));
                    if (observed.second_result !== head.result.second_result)
                        report_mismatch($sformatf(
                            "op %0d in (%0d, %0d): second_result want %0d got %0d",
                            head.op, head.first_value, head.second_value,
                            head.result.second_result, observed.second_result));
                    if (m_data[39:33] !== 7'd0)
                        report_mismatch($sformatf("padding bits not zero: %h", m_data[39:33]));
                end
            end
            if (s_valid && s_ready)
            begin
                incoming.op           = s_user;
                incoming.first_value  = s_data[15:0];
                incoming.second_value = s_data[31:16];
                incoming.result       = convert_pair(s_user, s_data[15:0], s_data[31:16]);
                awaited_results.push_back(incoming);
            end
            words_in_flight <= awaited_results.size();
        end
    end

endmodule

@@ bench/tb_polar_rectangular_converter.sv @@
// Testbench top for the polar/rectangular converter: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_polar_rectangular_converter;
    import prc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'h0;   // [15:0] first_value, [31:16] second_value
    logic        s_axis_tuser = 1'b0;    // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [16:0] first_result, [32:17] second_result

    int mismatch_total;
    int words_in_flight;
    int cycle_count = 0;
    bit burst_mode = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    polar_rectangular_converter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    prc_conversion_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .s_data          (s_axis_tdata),
        .s_user          (s_axis_tuser),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_data          (m_axis_tdata),
        .mismatch_count  (mismatch_total),
        .words_in_flight (words_in_flight)
    );

    // Wait before the next word; zero throughout a burst phase.
    function automatic int pick_gap();
        return burst_mode ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Operand values weighted toward extremes and small magnitudes.
    function automatic logic [15:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            1, 2:
            begin
                v = int'($urandom_range(0, 128)) - 64;
                return 16'(v);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic op, input logic [15:0] first_value,
                             input logic [15:0] second_value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {second_value, first_value};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Hold the input until every pending result has come back.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (words_in_flight != 0);
    endtask

    // Output back-pressure: a random stall before each result word.
    initial
    begin
        int stall;
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main stimulus sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rectangular to polar: origin, axes, corners and tiny vectors.
        send_word(OP_TO_POLAR, 16'h0000, 16'h0000);
        send_word(OP_TO_POLAR, 16'h7FFF, 16'h0000);
        send_word(OP_TO_POLAR, 16'h8000, 16'h0000);
        send_word(OP_TO_POLAR, 16'hFFFF, 16'h0000);
        send_word(OP_TO_POLAR, 16'h0000, 16'h7FFF);
        send_word(OP_TO_POLAR, 16'h0000, 16'h8000);
        send_word(OP_TO_POLAR, 16'h7FFF, 16'h7FFF);
        send_word(OP_TO_POLAR, 16'h8000, 16'h8000);
        send_word(OP_TO_POLAR, 16'h8000, 16'h7FFF);
        send_word(OP_TO_POLAR, 16'h7FFF, 16'h8000);
        send_word(OP_TO_POLAR, 16'h0001, 16'h0001);
        send_word(OP_TO_POLAR, 16'hFFFF, 16'hFFFF);

        // Polar to rectangular: quadrant boundaries, negative and zero radius.
        send_word(OP_TO_RECT, 16'h7FFF, 16'h0000);
        send_word(OP_TO_RECT, 16'h7FFF, 16'h4000);
        send_word(OP_TO_RECT, 16'h7FFF, 16'h3FFF);
        send_word(OP_TO_RECT, 16'h7FFF, 16'h8000);
        send_word(OP_TO_RECT, 16'h7FFF, 16'hC000);
        send_word(OP_TO_RECT, 16'h7FFF, 16'hBFFF);
        send_word(OP_TO_RECT, 16'h7FFF, 16'h2000);
        send_word(OP_TO_RECT, 16'h8000, 16'h4000);
        send_word(OP_TO_RECT, 16'h8000, 16'hC000);
        send_word(OP_TO_RECT, 16'h8000, 16'h0000);
        send_word(OP_TO_RECT, 16'h0000, 16'h1234);
        send_word(OP_TO_RECT, 16'hFFFF, 16'hFFFF);

        drain_pipeline();

        // Random words in phases, alternating gapped traffic and bursts.
        for (int phase = 0; phase < 5; phase++)
        begin
            burst_mode = (phase % 2) == 1;
            for (int k = 0; k < RANDOM_WORDS / 5; k++)
                send_word($urandom_range(0, 1) ? OP_TO_RECT : OP_TO_POLAR,
                          pick_value(), pick_value());
            if (phase == 2)
                drain_pipeline();
        end
        burst_mode = 1'b0;

        drain_pipeline();
        repeat (40) @(posedge clk);

        if (mismatch_total == 0 && words_in_flight == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/prc_pkg.sv
rtl/core/polar_rectangular_converter.sv
bench/prc_conversion_checker.sv
bench/tb_polar_rectangular_converter.sv
